// ----- sv/fpcv_pkg.sv -----
// Package for the camera view matrix block: formats, constants, sequencer states.
// Used by every module of the block; depends on nothing.
package fpcv_pkg;

  localparam int CordicStepsDef = 16;
  localparam int CordicStepsMax = 24;

  localparam logic signed [17:0] AngPi     = 18'sd25736;
  localparam logic signed [17:0] AngHalfPi = 18'sd12868;
  localparam logic signed [17:0] AngTwoPi  = 18'sd51472;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;

  localparam logic [0:0] OpSet  = 1'b0;
  localparam logic [0:0] OpMove = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PITCH,
    ST_YAW,
    ST_MUL,
    ST_TRANS,
    ST_OUT
  } fpcv_state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } fpcv_cordic_ctl_t;

  // Q3.28 arctangent table
  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    case (i)
      5'd0:  atan_q28 = 32'sd210828714;
      5'd1:  atan_q28 = 32'sd124459457;
      5'd2:  atan_q28 = 32'sd65760959;
      5'd3:  atan_q28 = 32'sd33381290;
      5'd4:  atan_q28 = 32'sd16755422;
      5'd5:  atan_q28 = 32'sd8385879;
      5'd6:  atan_q28 = 32'sd4193963;
      5'd7:  atan_q28 = 32'sd2097109;
      5'd8:  atan_q28 = 32'sd1048571;
      5'd9:  atan_q28 = 32'sd524287;
      5'd10: atan_q28 = 32'sd262144;
      5'd11: atan_q28 = 32'sd131072;
      5'd12: atan_q28 = 32'sd65536;
      5'd13: atan_q28 = 32'sd32768;
      5'd14: atan_q28 = 32'sd16384;
      5'd15: atan_q28 = 32'sd8192;
      5'd16: atan_q28 = 32'sd4096;
      5'd17: atan_q28 = 32'sd2048;
      5'd18: atan_q28 = 32'sd1024;
      5'd19: atan_q28 = 32'sd512;
      5'd20: atan_q28 = 32'sd256;
      5'd21: atan_q28 = 32'sd128;
      5'd22: atan_q28 = 32'sd64;
      5'd23: atan_q28 = 32'sd32;
      default: atan_q28 = 32'sd0;
    endcase
  endfunction

endpackage

// ----- sv/fpcv_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on fpcv_pkg. Angle in Q4.13, cos/sin out in clamped Q2.14.
module fpcv_cordic #(
  parameter int CORDIC_STEPS = fpcv_pkg::CordicStepsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpcv_pkg::fpcv_cordic_ctl_t ctl,
  input  logic signed [17:0]        ang,
  output logic                      done,
  output logic signed [15:0]        cos_q14,
  output logic signed [15:0]        sin_q14
);
  import fpcv_pkg::*;

  localparam int StepW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [34:0] z_r, z_nxt;
  logic [StepW-1:0]   i_r, i_nxt;
  logic               run_r, run_nxt;
  logic signed [33:0] dx, dy, xr, yr;
  logic signed [17:0] cq, sq;

  always_comb begin
    dx = x_r >>> i_r;
    dy = y_r >>> i_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r; run_nxt = run_r;
    if (ctl.start) begin
      x_nxt = 34'(CordicGain);
      y_nxt = '0;
      z_nxt = 35'(ang) <<< 15;
      i_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!z_r[34]) begin
        x_nxt = x_r - dy;
        y_nxt = y_r + dx;
        z_nxt = z_r - 35'(atan_q28(5'(i_r)));
      end else begin
        x_nxt = x_r + dy;
        y_nxt = y_r - dx;
        z_nxt = z_r + 35'(atan_q28(5'(i_r)));
      end
      i_nxt = i_r + 1'b1;
      if (i_r == StepW'(CORDIC_STEPS - 1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt;
  end

  assign done = ctl.busy && !run_r;

  always_comb begin
    xr = (x_r + 34'sd32768) >>> 16;
    yr = (y_r + 34'sd32768) >>> 16;
    cq = 18'(xr);
    sq = 18'(yr);
    if (xr > 34'sd16384) cq = 18'sd16384;
    else if (xr < -34'sd16384) cq = -18'sd16384;
    if (yr > 34'sd16384) sq = 18'sd16384;
    else if (yr < -34'sd16384) sq = -18'sd16384;
    cos_q14 = 16'(cq);
    sin_q14 = 16'(sq);
  end
endmodule

// ----- sv/fpcv_mac.sv -----
// Shared 32x17 multiplier with a wide accumulator for products and dot products.
// Depends on fpcv_pkg for nothing but the house import style.
module fpcv_mac (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [16:0] b,
  output logic signed [50:0] acc
);
  import fpcv_pkg::*;

  logic signed [48:0] prod_r;
  logic               en_r;
  logic signed [50:0] acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (clr) acc_nxt = '0;
    else if (en_r) acc_nxt = acc_r + 51'(prod_r);
  end

  // the product issued with a clear lands in the next cycle, on the cleared sum
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    en_r   <= en;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

// ----- sv/fp_camera_view_matrix.sv -----
// Top level of the first-person camera view matrix block.
// Depends on fpcv_pkg, fpcv_cordic and fpcv_mac.
//
// channel | dir | beat contents
// in_     | in  | tdata: op, pos_x, pos_y, pos_z, pitch_in, yaw_in
// out_    | out | tdata: side_x/y, up_x/y/z, fwd_x/y/z, trans_side/up/fwd
//
// A beat is accepted only in the idle state, so no new beat is taken before the last
// one is through: two CORDIC runs (pitch, then yaw), four products and three
// dot products on the one shared multiplier, a hand-off state and an idle state.
// The result is loaded into the output register in the hand-off state.
// in_tready is low while a beat is in progress; a result left waiting in the output
// register holds the next beat only at its hand-off cycle.
// Reset clears the camera state, the sequencer and the output valid flag.
module fp_camera_view_matrix #(
  parameter int CORDIC_STEPS = fpcv_pkg::CordicStepsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[0], pos_x[32:1], pos_y[64:33], pos_z[96:65], pitch_in[113:97],
  // yaw_in[130:114], zero fill to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // side_x, side_y, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z (16 each, [127:0]),
  // trans_side[159:128], trans_up[191:160], trans_fwd[223:192]
  output logic [223:0] out_tdata
);
  import fpcv_pkg::*;

  fpcv_state_t st_r, st_nxt;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] pitch_r, yaw_r;
  logic               yflip_r;
  logic signed [15:0] cp_r, sp_r, cy_r, sy_r;
  logic signed [15:0] fx_r, fy_r, ux_r, uy_r;
  logic signed [31:0] ts_r, tu_r, tf_r;
  logic [4:0]         k_r, k_nxt;
  fpcv_cordic_ctl_t   cctl;
  logic               cdone;
  logic signed [17:0] cang;
  logic signed [15:0] ccos, csin;
  logic               mclr, men;
  logic signed [31:0] ma;
  logic signed [16:0] mb;
  logic signed [50:0] macc;
  logic               out_valid_r;
  logic [223:0]       out_data_r;
  logic               out_free;

  // input decode
  logic               op;
  logic signed [31:0] pin [3];
  logic signed [16:0] pit_in, yaw_in;
  assign op     = in_tdata[0];
  assign pin[0] = in_tdata[32:1];
  assign pin[1] = in_tdata[64:33];
  assign pin[2] = in_tdata[96:65];
  assign pit_in = in_tdata[113:97];
  assign yaw_in = in_tdata[130:114];

  logic acc_in;
  assign acc_in = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);

  // output register free for a new result beat
  assign out_free = !out_valid_r || out_tready;

  // angle update, narrow enough to stay combinational
  logic signed [18:0] pit_sum, yaw_sum, yaw_w;
  logic signed [15:0] pit_cl;
  logic signed [32:0] psum [3];
  always_comb begin
    pit_sum = 19'(pit_in) + ((op == OpMove) ? 19'(pitch_r) : 19'sd0);
    yaw_sum = 19'(yaw_in) + ((op == OpMove) ? 19'(yaw_r) : 19'sd0);
    yaw_w = yaw_sum;
    // at most two wraps: |sum| < 4*pi
    if (yaw_w > 19'(AngPi)) yaw_w = yaw_w - 19'(AngTwoPi);
    if (yaw_w > 19'(AngPi)) yaw_w = yaw_w - 19'(AngTwoPi);
    if (yaw_w < -19'(AngPi)) yaw_w = yaw_w + 19'(AngTwoPi);
    if (yaw_w < -19'(AngPi)) yaw_w = yaw_w + 19'(AngTwoPi);
    if (pit_sum > 19'(AngHalfPi)) pit_cl = 16'(AngHalfPi);
    else if (pit_sum < -19'(AngHalfPi)) pit_cl = -16'(AngHalfPi);
    else pit_cl = 16'(pit_sum);
    for (int i = 0; i < 3; i++) psum[i] = 33'(pos_r[i]) + 33'(pin[i]);
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    k_nxt  = k_r;
    case (st_r)
      ST_IDLE:  if (acc_in) st_nxt = ST_PITCH;
      ST_PITCH: if (cdone) st_nxt = ST_YAW;
      ST_YAW:   if (cdone) begin st_nxt = ST_MUL; k_nxt = '0; end
      ST_MUL: begin
        k_nxt = k_r + 1'b1;
        if (k_r == 5'd15) begin st_nxt = ST_TRANS; k_nxt = '0; end
      end
      ST_TRANS: begin
        k_nxt = k_r + 1'b1;
        if (k_r == 5'd14) st_nxt = ST_OUT;
      end
      ST_OUT:   if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // CORDIC control
  logic cstart;
  always_comb begin
    cstart = (st_r == ST_IDLE && acc_in) || (st_r == ST_PITCH && cdone);
    cctl.start = cstart;
    cctl.busy  = (st_r == ST_PITCH) || (st_r == ST_YAW);
    if (st_r == ST_IDLE) cang = 18'(pit_cl);
    else if (yaw_r > 16'(AngHalfPi)) cang = 18'(yaw_r) - AngPi;
    else if (yaw_r < -16'(AngHalfPi)) cang = 18'(yaw_r) + AngPi;
    else cang = 18'(yaw_r);
  end

  fpcv_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .ctl(cctl), .ang(cang), .done(cdone),
    .cos_q14(ccos), .sin_q14(csin)
  );

  // Multiplier schedule. MUL: 4 products, each issued at k%4 == 0 and read at k%4 == 3.
  // TRANS: 3 dot products of 3 terms, issue k%5 in 0..2, read at k%5 == 4.
  logic [1:0] tv, tt;
  logic [4:0] tk;
  logic       tissue;
  logic signed [16:0] vsel [3];
  always_comb begin
    mclr = 1'b0; men = 1'b0; ma = '0; mb = '0;
    tv = '0; tt = '0; tk = '0; tissue = 1'b0;
    vsel[0] = '0; vsel[1] = '0; vsel[2] = '0;
    if (st_r == ST_MUL) begin
      mclr = (k_r[1:0] == 2'd0);
      men  = (k_r[1:0] == 2'd0);
      case (k_r[3:2])
        2'd0: begin ma = 32'(cy_r); mb = 17'(cp_r); end
        2'd1: begin ma = 32'(sy_r); mb = 17'(cp_r); end
        2'd2: begin ma = 32'(cy_r); mb = 17'(sp_r); end
        default: begin ma = 32'(sy_r); mb = 17'(sp_r); end
      endcase
    end else if (st_r == ST_TRANS) begin
      if (k_r < 5'd5) tv = 2'd0; else if (k_r < 5'd10) tv = 2'd1; else tv = 2'd2;
      tk = k_r - 5'({tv, 2'b00}) - 5'(tv);
      tt = tk[1:0];
      case (tv)
        2'd0: begin vsel[0] = 17'(fy_r); vsel[1] = -17'(fx_r); vsel[2] = '0; end
        2'd1: begin vsel[0] = 17'(ux_r); vsel[1] = 17'(uy_r); vsel[2] = 17'(cp_r); end
        default: begin vsel[0] = 17'(fx_r); vsel[1] = 17'(fy_r); vsel[2] = 17'(sp_r); end
      endcase
      tissue = (tk < 5'd3);
      mclr = (tk == 5'd0);
      men  = tissue;
      if (tissue) begin ma = pos_r[tt]; mb = vsel[tt]; end
    end
  end

  fpcv_mac u_mac (.clk, .clr(mclr), .en(men), .a(ma), .b(mb), .acc(macc));

  // rounding of products and dot products
  logic signed [50:0] rq14, nd;
  logic signed [36:0] tq;
  logic signed [31:0] tsat;
  always_comb begin
    rq14 = (macc + 51'sd8192) >>> 14;
    nd   = (-macc + 51'sd8192) >>> 14;
    if (nd > 51'sd2147483647) tsat = 32'sh7fffffff;
    else if (nd < -51'sd2147483648) tsat = 32'sh80000000;
    else tsat = 32'(nd);
    tq = 37'(rq14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      k_r         <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
      if (st_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (acc_in) begin
        pitch_r <= pit_cl;
        yaw_r   <= 16'(yaw_w);
        for (int i = 0; i < 3; i++) begin
          if (op == OpSet) pos_r[i] <= pin[i];
          else if (psum[i] > 33'sd2147483647) pos_r[i] <= 32'sh7fffffff;
          else if (psum[i] < -33'sd2147483648) pos_r[i] <= 32'sh80000000;
          else pos_r[i] <= 32'(psum[i]);
        end
      end
    end
    if (st_r == ST_IDLE) yflip_r <= 1'b0;
    if (st_r == ST_PITCH && cdone) begin
      cp_r <= ccos; sp_r <= csin;
      yflip_r <= (yaw_r > 16'(AngHalfPi)) || (yaw_r < -16'(AngHalfPi));
    end
    if (st_r == ST_YAW && cdone) begin
      cy_r <= yflip_r ? -ccos : ccos;
      sy_r <= yflip_r ? -csin : csin;
    end
    if (st_r == ST_MUL && k_r[1:0] == 2'd3) begin
      case (k_r[3:2])
        2'd0: fx_r <= 16'(tq);
        2'd1: fy_r <= 16'(tq);
        2'd2: ux_r <= -16'(tq);
        default: uy_r <= -16'(tq);
      endcase
    end
    if (st_r == ST_TRANS && tk == 5'd4) begin
      case (tv)
        2'd0: ts_r <= tsat;
        2'd1: tu_r <= tsat;
        default: tf_r <= tsat;
      endcase
    end
    if (st_r == ST_OUT && out_free) begin
      out_data_r <= {tf_r, tu_r, ts_r, sp_r, fy_r, fx_r, cp_r, uy_r, ux_r,
                     -fx_r, fy_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // CORDIC only runs while the sequencer waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    u_cordic.run_r |-> (st_r == ST_PITCH) || (st_r == ST_YAW))
    else $error("cordic running outside its states");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> (st_r == ST_PITCH))
    else $error("beat accepted but sequencer did not start");
endmodule

// ----- tb/tb_fp_camera_view_matrix.sv -----
// Self-checking testbench for fp_camera_view_matrix: random camera beats in, view matrix out.
// Depends on fpcv_pkg and the block's RTL; holds its own fixed-point camera predictor.
`timescale 1ns / 1ps

module tb_fp_camera_view_matrix;
  import fpcv_pkg::*;

  localparam int Steps = CordicStepsDef;
  localparam int Latency = 2 * (Steps + 2) + 40;
  localparam int WatchLimit = 20000;

  // last member sits in the lowest bits: op at bit 0, yaw at the top
  typedef struct packed {
    logic signed [16:0] yaw;
    logic signed [16:0] pitch;
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
    logic [0:0]         op;
  } cam_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [223:0] out_tdata;

  fp_camera_view_matrix #(.CORDIC_STEPS(Steps)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cam_beat_t pending_beats[$];
  logic [223:0] view_expected[$];
  int mismatches = 0;
  int idle_cycles = 0;

  // predictor state
  longint cam_x = 0, cam_y = 0, cam_z = 0, cam_pch = 0, cam_yw = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    return tbl[i];
  endfunction

  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874; y = 0; z = ang * 32768;
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = clampl(floor_shr(x + 32768, 16), -16384, 16384);
    s = clampl(floor_shr(y + 32768, 16), -16384, 16384);
  endtask

  function automatic longint mul_q14(longint a, longint b);
    return floor_shr(a * b + 8192, 14);
  endfunction

  function automatic longint translation(longint vx, longint vy, longint vz,
                                         longint px, longint py, longint pz);
    longint d;
    d = vx * px + vy * py + vz * pz;
    return clampl(floor_shr(-d + 8192, 14), -64'sd2147483648, 64'sd2147483647);
  endfunction

  task automatic predict_view(input cam_beat_t b);
    longint pch, yw, cp, sp, cy, sy, fx, fy, fz, ux, uy, uz;
    logic [223:0] r;
    if (b.op == OpMove) begin
      cam_x = clampl(cam_x + b.px, -64'sd2147483648, 64'sd2147483647);
      cam_y = clampl(cam_y + b.py, -64'sd2147483648, 64'sd2147483647);
      cam_z = clampl(cam_z + b.pz, -64'sd2147483648, 64'sd2147483647);
      pch = cam_pch + b.pitch;
      yw = cam_yw + b.yaw;
    end else begin
      cam_x = b.px; cam_y = b.py; cam_z = b.pz;
      pch = b.pitch;
      yw = b.yaw;
    end
    while (yw > AngPi) yw -= AngTwoPi;
    while (yw < -AngPi) yw += AngTwoPi;
    cam_yw = yw;
    cam_pch = clampl(pch, -AngHalfPi, AngHalfPi);
    cordic_sincos(cam_pch, cp, sp);
    if (yw > AngHalfPi) begin
      cordic_sincos(yw - AngPi, cy, sy);
      cy = -cy; sy = -sy;
    end else if (yw < -AngHalfPi) begin
      cordic_sincos(yw + AngPi, cy, sy);
      cy = -cy; sy = -sy;
    end else begin
      cordic_sincos(yw, cy, sy);
    end
    fx = mul_q14(cy, cp); fy = mul_q14(sy, cp); fz = sp;
    ux = -mul_q14(cy, sp); uy = -mul_q14(sy, sp); uz = cp;
    r[15:0]    = fy[15:0];
    r[31:16]   = 16'(-fx);
    r[47:32]   = ux[15:0];
    r[63:48]   = uy[15:0];
    r[79:64]   = uz[15:0];
    r[95:80]   = fx[15:0];
    r[111:96]  = fy[15:0];
    r[127:112] = fz[15:0];
    r[159:128] = 32'(translation(fy, -fx, 0, cam_x, cam_y, cam_z));
    r[191:160] = 32'(translation(ux, uy, uz, cam_x, cam_y, cam_z));
    r[223:192] = 32'(translation(fx, fy, fz, cam_x, cam_y, cam_z));
    view_expected.push_back(r);
  endtask

  function automatic logic [16:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 17'($urandom);
      1: return 17'(-51472 + int'($urandom_range(0, 102944)));
      2: return 17'(int'($urandom_range(0, 200)) - 100);
      default: return 17'(-25736 + int'($urandom_range(0, 51472)));
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 9) :
                                       32'h80000000 + $urandom_range(0, 9);
      default: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic cam_beat_t mk_beat(logic [0:0] op, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [16:0] p, logic [16:0] w);
    cam_beat_t b;
    b.op = op; b.px = x; b.py = y; b.pz = z; b.pitch = p; b.yaw = w;
    return b;
  endfunction

  // handshake flags sampled at the rising edge
  logic in_tready_q = 1'b0;
  logic out_took = 1'b0;
  always @(posedge clk) begin
    in_tready_q <= in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_view(cam_beat_t'(in_tdata[130:0]));
      idle_cycles <= 0;
    end else if (rst_n && out_tvalid && out_tready) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready_q) begin
        // beat taken at the last rising edge
        send_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
        if (send_gap == 0 && pending_beats.size() > 0) begin
          in_tdata <= {5'b0, pending_beats.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end else if (!in_tvalid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_beats.size() > 0) begin
          in_tdata <= {5'b0, pending_beats.pop_front()};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // monitor
  logic [223:0] want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (view_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = view_expected.pop_front();
        for (int f = 0; f < 11; f++) begin
          if (f < 8 ? out_tdata[16*f +: 16] !== want[16*f +: 16]
                    : out_tdata[128+32*(f-8) +: 32] !== want[128+32*(f-8) +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h got %h", f,
                       f < 8 ? 32'(want[16*f +: 16]) : want[128+32*(f-8) +: 32],
                       f < 8 ? 32'(out_tdata[16*f +: 16]) : out_tdata[128+32*(f-8) +: 32]);
          end
        end
      end
    end
  end

  // receiver stalls, with one long hold-off while the sender keeps offering
  int recv_wait = 0;
  int hold_off = 0;
  int taken = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        taken++;
        if (taken == 40) hold_off = 600;
        recv_wait = (taken > 300 && taken < 500) ? 0 : $urandom_range(0, 14);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    pending_beats.push_back(mk_beat(OpSet, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk_beat(OpSet, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                    17'sd51472, -17'sd51472));
    pending_beats.push_back(mk_beat(OpSet, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                    -17'sd51472, 17'sd51472));
    pending_beats.push_back(mk_beat(OpSet, 32'h00010000, 32'hffff0000, 0, 17'sd12868, 17'sd25736));
    pending_beats.push_back(mk_beat(OpSet, 0, 0, 32'h00010000, -17'sd12868, -17'sd25736));
    pending_beats.push_back(mk_beat(OpSet, 0, 0, 0, 17'sd12869, 17'sd25737));
    pending_beats.push_back(mk_beat(OpSet, 0, 0, 0, 17'sd0, 17'sd12869));
    pending_beats.push_back(mk_beat(OpSet, 0, 0, 0, 17'sd0, -17'sd12869));
    pending_beats.push_back(mk_beat(OpSet, 0, 0, 0, 17'h10000, 17'h0ffff));
    pending_beats.push_back(mk_beat(OpSet, 32'h7ffffff0, 32'h80000010, 0, 17'sd100, 17'sd20000));
    // saturating moves and yaw wrap on accumulation
    pending_beats.push_back(mk_beat(OpMove, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                    17'sd51472, 17'sd51472));
    pending_beats.push_back(mk_beat(OpMove, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                    -17'sd51472, -17'sd51472));
    pending_beats.push_back(mk_beat(OpMove, 0, 0, 0, 17'sd12868, 17'sd25736));
    pending_beats.push_back(mk_beat(OpMove, 0, 0, 0, 17'sd12868, 17'sd25736));
    pending_beats.push_back(mk_beat(OpMove, 32'hffffffff, 1, 32'hffffffff, -17'sd1, -17'sd1));
    pending_beats.push_back(mk_beat(OpMove, 32'h80000000, 32'h80000000, 32'h80000000,
                                    17'h10000, 17'h10000));
    for (int i = 0; i < 1950; i++)
      pending_beats.push_back(mk_beat(1'($urandom_range(0, 3) != 0), rand_pos(), rand_pos(),
                                      rand_pos(), rand_angle(), rand_angle()));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_beats.size() == 0 && !in_tvalid && view_expected.size() == 0);
    repeat (Latency) @(posedge clk);
    if (mismatches == 0 && view_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
